// ===== rtl/generation_tagged_key_slot_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// generation tagged key slot table - assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef GENERATION_TAGGED_KEY_SLOT_TABLE_CORE_DEFINES_SVH
`define GENERATION_TAGGED_KEY_SLOT_TABLE_CORE_DEFINES_SVH

// property holds at every edge outside reset
`define GTKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define GTKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gtkst_pkg.sv =====
// ----------------------------------------------------------------------------
// gtkst_pkg
// sizes, codes, word types and helpers of the key slot table
// ----------------------------------------------------------------------------
`default_nettype none

package gtkst_pkg;

  localparam int unsigned SLOTS    = 512;
  localparam int unsigned SEQ_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned GROUP_W  = 32;
  localparam int unsigned GROUPS   = SLOTS / GROUP_W;
  localparam int unsigned BIT_W    = $clog2(GROUP_W);
  localparam int unsigned GRP_W    = IDX_W - BIT_W;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned DATA_W   = 64;

  localparam logic [HANDLE_W-1:0] FLAG_SET    = 32'h8000_0000;
  localparam logic [HANDLE_W-1:0] FLAG_CUSTOM = 32'h4000_0000;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_FULL       = 2'd2,
    ST_NOT_CUSTOM = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    K_CREATE = 3'd0,
    K_DELETE = 3'd1,
    K_GET    = 3'd2,
    K_SET    = 3'd3,
    K_REJECT = 3'd4
  } kind_e;

  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] key_handle;
    logic [DATA_W-1:0]   destructor_ref;
    logic [DATA_W-1:0]   value;
  } in_word_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] new_handle;
    logic [DATA_W-1:0]   read_value;
  } out_word_t;

  typedef struct packed {
    kind_e             kind;
    status_e           rej_status;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] destructor_ref;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // position of the lowest set bit, zero when none
  function automatic logic [BIT_W-1:0] lowest_one(input logic [GROUP_W-1:0] x);
    logic [GROUP_W-1:0] iso;
    logic [BIT_W-1:0]   enc;
    iso = x & (~x + GROUP_W'(1));
    enc = '0;
    for (int j = 0; j < GROUP_W; j++) begin
      if (iso[j]) begin
        enc = enc | BIT_W'(j);
      end
    end
    return enc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/generation_tagged_key_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// generation_tagged_key_slot_table_core
// generational key slot table: create, delete, get and set on 512 slots
// ----------------------------------------------------------------------------
// request words enter on in_valid_i/in_ready_o, one result word per request
// leaves on out_valid_o/out_ready_i
// the front end classifies requests into a two word queue; the back end runs
// a read-modify-write on the slot memories and fills a result register
// a rejected handle or a full table is answered straight from idle; delete,
// get and set go through the registered memory read to the execute step,
// and create first takes the find step, the extra free map read of the
// lowest-free-slot search; the back end takes a new word only in idle, once
// the result register is free or being read
// after reset a clearing pass zeroes sequences, tags, values and the free
// map; in_ready_o stays low until it is done
// a stalled receiver holds the result register; up to two more words are
// queued, then in_ready_o drops
// ----------------------------------------------------------------------------
`default_nettype none

module generation_tagged_key_slot_table_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gtkst_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gtkst_pkg::out_word_t  out_word_o
);
  import gtkst_pkg::*;

  cmd_t       cmd;
  logic       cmd_valid, cmd_ready;
  back_stat_t back_stat;

  gtkst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .back_stat_i (back_stat),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  gtkst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .back_stat_o (back_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/gtkst_front.sv =====
// ----------------------------------------------------------------------------
// gtkst_front
// accepts request words, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module gtkst_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gtkst_pkg::in_word_t    in_word_i,
  input  gtkst_pkg::back_stat_t  back_stat_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output gtkst_pkg::cmd_t        cmd_o
);
  import gtkst_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  cmd_t       cmd_in;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    cmd_in.rej_status     = ST_OK;
    cmd_in.index          = in_word_i.key_handle[IDX_W-1:0];
    cmd_in.destructor_ref = in_word_i.destructor_ref;
    cmd_in.value          = in_word_i.value;
    priority if (in_word_i.op == OP_CREATE) begin
      cmd_in.kind = K_CREATE;
    end else if ((in_word_i.key_handle & FLAG_CUSTOM) == '0) begin
      cmd_in.kind       = K_REJECT;
      cmd_in.rej_status = ST_NOT_CUSTOM;
    end else if ((in_word_i.key_handle & FLAG_SET) == '0 ||
                 in_word_i.key_handle[29:0] >= 30'(SLOTS)) begin
      cmd_in.kind       = K_REJECT;
      cmd_in.rej_status = ST_INVALID;
    end else begin
      unique case (in_word_i.op)
        OP_DELETE: cmd_in.kind = K_DELETE;
        OP_GET:    cmd_in.kind = K_GET;
        default:   cmd_in.kind = K_SET;
      endcase
    end
  end

  assign in_ready_o  = (count_q != QDEPTH) && !back_stat_i.clearing;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gtkst_back.sv =====
// ----------------------------------------------------------------------------
// gtkst_back
// slot memories, free slot search, read-modify-write sequencer, result word
// ----------------------------------------------------------------------------
`default_nettype none
`include "generation_tagged_key_slot_table_core_defines.svh"

module gtkst_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  gtkst_pkg::cmd_t        cmd_i,
  output gtkst_pkg::back_stat_t  back_stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gtkst_pkg::out_word_t   out_word_o
);
  import gtkst_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FIND  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [GROUPS-1:0]   full_q, full_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [GROUP_W-1:0]  map_new_q, map_new_d;
  cmd_t                cmd_q;
  out_word_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [SEQ_BITS-1:0] seq_mem  [SLOTS];
  logic [SEQ_BITS-1:0] tag_mem  [SLOTS];
  logic [DATA_W-1:0]   val_mem  [SLOTS];
  logic [DATA_W-1:0]   dtor_mem [SLOTS];
  logic [GROUP_W-1:0]  map_mem  [GROUPS];

  logic [SEQ_BITS-1:0] rd_seq_q, rd_tag_q;
  logic [DATA_W-1:0]   rd_val_q;
  logic [GROUP_W-1:0]  rd_map_q;

  logic [IDX_W-1:0]    rd_idx, wr_idx, found_idx;
  logic [GRP_W-1:0]    rd_grp, wr_grp, free_grp;
  logic [BIT_W-1:0]    found_bit;
  logic                any_free, pop, in_use;
  logic                seq_we, tag_we, val_we, dtor_we, map_we;
  logic [SEQ_BITS-1:0] seq_wd, tag_wd;
  logic [DATA_W-1:0]   val_wd;
  logic [GROUP_W-1:0]  map_wd;

  assign cmd_ready_o          = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign pop                  = cmd_valid_i && cmd_ready_o;
  assign back_stat_o.clearing = (state_q == S_CLEAR);
  assign out_valid_o          = out_valid_q;
  assign out_word_o           = out_q;

  assign any_free  = |(~full_q);
  assign free_grp  = GRP_W'(lowest_one(GROUP_W'(~full_q)));
  assign found_bit = lowest_one(~rd_map_q);
  assign found_idx = {idx_q[IDX_W-1:BIT_W], found_bit};
  assign in_use    = rd_seq_q[0];

  assign rd_idx = (state_q == S_FIND) ? found_idx : cmd_i.index;
  assign rd_grp = (cmd_i.kind == K_CREATE) ? free_grp : cmd_i.index[IDX_W-1:BIT_W];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    full_d      = full_q;
    idx_d       = idx_q;
    map_new_d   = map_new_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    seq_we      = 1'b0;
    tag_we      = 1'b0;
    val_we      = 1'b0;
    dtor_we     = 1'b0;
    map_we      = 1'b0;
    wr_idx      = idx_q;
    wr_grp      = idx_q[IDX_W-1:BIT_W];
    seq_wd      = rd_seq_q + SEQ_BITS'(1);
    tag_wd      = rd_seq_q;
    val_wd      = '0;
    map_wd      = '0;
    unique case (state_q)
      S_CLEAR: begin
        seq_we = 1'b1;
        tag_we = 1'b1;
        val_we = 1'b1;
        map_we = 1'b1;
        wr_idx = clr_q;
        wr_grp = clr_q[GRP_W-1:0];
        seq_wd = '0;
        tag_wd = '0;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          idx_d = cmd_i.index;
          priority if (cmd_i.kind == K_REJECT) begin
            out_d       = '{status: cmd_i.rej_status, new_handle: '0, read_value: '0};
            out_valid_d = 1'b1;
          end else if (cmd_i.kind == K_CREATE) begin
            if (!any_free) begin
              out_d       = '{status: ST_FULL, new_handle: '0, read_value: '0};
              out_valid_d = 1'b1;
            end else begin
              idx_d   = {free_grp, BIT_W'(0)};
              state_d = S_FIND;
            end
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_FIND: begin
        idx_d     = found_idx;
        map_new_d = rd_map_q | (GROUP_W'(1) << found_bit);
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        out_d       = '{status: ST_OK, new_handle: '0, read_value: '0};
        unique case (cmd_q.kind)
          K_CREATE: begin
            seq_we           = 1'b1;
            dtor_we          = 1'b1;
            map_we           = 1'b1;
            map_wd           = map_new_q;
            full_d[wr_grp]   = &map_new_q;
            out_d.new_handle = FLAG_SET | FLAG_CUSTOM | HANDLE_W'(idx_q);
          end
          K_DELETE: begin
            if (in_use) begin
              seq_we         = 1'b1;
              map_we         = 1'b1;
              map_wd         = rd_map_q & ~(GROUP_W'(1) << idx_q[BIT_W-1:0]);
              full_d[wr_grp] = 1'b0;
            end else begin
              out_d.status = ST_INVALID;
            end
          end
          K_GET: begin
            if (in_use && rd_tag_q == rd_seq_q) begin
              out_d.read_value = rd_val_q;
            end else begin
              val_we       = 1'b1;
              out_d.status = in_use ? ST_OK : ST_INVALID;
            end
          end
          K_SET: begin
            if (in_use) begin
              tag_we = 1'b1;
              val_we = 1'b1;
              val_wd = cmd_q.value;
            end else begin
              out_d.status = ST_INVALID;
            end
          end
          default: begin
            out_d.status = cmd_q.rej_status;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (seq_we) begin
      seq_mem[wr_idx] <= seq_wd;
    end
    rd_seq_q <= seq_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[wr_idx] <= tag_wd;
    end
    rd_tag_q <= tag_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_idx] <= val_wd;
    end
    rd_val_q <= val_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (dtor_we) begin
      dtor_mem[wr_idx] <= cmd_q.destructor_ref;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[wr_grp] <= map_wd;
    end
    rd_map_q <= map_mem[rd_grp];
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    idx_q     <= idx_d;
    map_new_q <= map_new_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  `GTKST_ASSERT(a_out_free_in_exec, (state_q == S_FIND || state_q == S_EXEC) |-> !out_valid_q, "result register busy while executing")
  `GTKST_ASSERT(a_no_pop_clearing, (state_q == S_CLEAR) |-> !cmd_ready_o, "command taken during clearing pass")
  `GTKST_ASSERT_NEXT(a_find_then_exec, state_q == S_FIND, state_q == S_EXEC, "search step not followed by execute")
  `GTKST_ASSERT(a_create_on_free, (state_q == S_EXEC && cmd_q.kind == K_CREATE) |-> !rd_seq_q[0], "free map disagrees with sequence")

endmodule

`default_nettype wire
